>>> hw/rtl/por_pkg.sv
package por_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned DNUM_W  = 22;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned Q100_W  = 8;

    // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y
    localparam int unsigned RECIP_W     = 13;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

    localparam logic [YEAR_W-1:0]  YEAR_MAX      = 14'd9999;
    localparam logic [DNUM_W-1:0]  DAYS_PER_YEAR = 22'd365;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [DAY_W-1:0]   first_start_day;
        logic [MONTH_W-1:0] first_start_month;
        logic [YEAR_W-1:0]  first_start_year;
        logic [DAY_W-1:0]   first_end_day;
        logic [MONTH_W-1:0] first_end_month;
        logic [YEAR_W-1:0]  first_end_year;
        logic [DAY_W-1:0]   second_start_day;
        logic [MONTH_W-1:0] second_start_month;
        logic [YEAR_W-1:0]  second_start_year;
        logic [DAY_W-1:0]   second_end_day;
        logic [MONTH_W-1:0] second_end_month;
        logic [YEAR_W-1:0]  second_end_year;
    } t_req_data;

    typedef struct packed {
        logic [DNUM_W-1:0] overlap_days;
        logic              bad_date;
    } t_rsp_data;

    // load strobes for the two conversion stages
    typedef struct packed {
        logic s1;
        logic s2;
    } t_stage_en;

    // Month length; zero for a month code that means nothing.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        begin
            unique case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
                4'd2:                                       len = leap ? 5'd29 : 5'd28;
                default:                                    len = 5'd0;
            endcase
            return len;
        end
    endfunction

    // Days before the first of the month, counting the year from March.
    function automatic logic [DOY_W-1:0] march_offset(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] off;
        begin
            unique case (m)
                4'd3:    off = 9'd0;
                4'd4:    off = 9'd31;
                4'd5:    off = 9'd61;
                4'd6:    off = 9'd92;
                4'd7:    off = 9'd122;
                4'd8:    off = 9'd153;
                4'd9:    off = 9'd184;
                4'd10:   off = 9'd214;
                4'd11:   off = 9'd245;
                4'd12:   off = 9'd275;
                4'd1:    off = 9'd306;
                4'd2:    off = 9'd337;
                default: off = 9'd0;
            endcase
            return off;
        end
    endfunction

endpackage

>>> hw/rtl/por_req_if.sv
interface por_req_if;
    logic                 valid;
    logic                 ready;
    por_pkg::t_req_data   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/por_rsp_if.sv
interface por_rsp_if;
    logic                 valid;
    logic                 ready;
    por_pkg::t_rsp_data   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/period_overlap_day_count.sv
// Counts the calendar days shared by two Gregorian periods, both end days
// included, with the 4/100/400 leap rule. Each request carries four dates
// (start and end of each period); each gives exactly one response with
// overlap_days and bad_date. Any impossible date (day 0 or past the month's
// end, month outside 1..12, year outside 1..9999) sets bad_date and forces
// the count to 0; a period that ends before it starts simply overlaps
// nothing. The block takes one request every clock cycle unless back-pressure
// stalls it, and passes each through four registers (input register, two
// date conversion stages, result register); the four dates are converted
// in parallel by dedicated units, so nothing is shared between requests.
// Back-pressure on the response side stalls the pipe one stage at a time,
// and empty stages keep taking requests while a result waits.
module period_overlap_day_count (
    input  logic    i_clk,
    input  logic    i_rst_n,
    por_req_if.sink   i_req,
    por_rsp_if.source o_rsp
);

    // Valid flags of the four stages
    logic r_v0, r_v1, r_v2, r_v3;
    logic w_adv0, w_adv1, w_adv2, w_adv3;

    por_pkg::t_req_data r_req;
    por_pkg::t_rsp_data r_rsp, n_rsp;
    por_pkg::t_stage_en w_en;

    logic [por_pkg::DNUM_W-1:0] w_s1, w_e1, w_s2, w_e2;
    logic                       w_ok_s1, w_ok_e1, w_ok_s2, w_ok_e2;
    logic [por_pkg::DNUM_W-1:0] w_lo, w_hi;
    logic                       w_ok;

    // Advance a stage when it holds an item and the next stage frees up
    assign w_adv3 = r_v2 && (!r_v3 || o_rsp.ready);
    assign w_adv2 = r_v1 && (!r_v2 || w_adv3);
    assign w_adv1 = r_v0 && (!r_v1 || w_adv2);
    assign i_req.ready = !r_v0 || w_adv1;
    assign w_adv0 = i_req.valid && i_req.ready;

    assign w_en.s1 = w_adv1;
    assign w_en.s2 = w_adv2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= w_adv0 || (r_v0 && !w_adv1);
            r_v1 <= w_adv1 || (r_v1 && !w_adv2);
            r_v2 <= w_adv2 || (r_v2 && !w_adv3);
            r_v3 <= w_adv3 || (r_v3 && !o_rsp.ready);
        end
    end

    // Input register: hold the request until stage 1 takes it
    always_ff @(posedge i_clk) begin
        if (w_adv0) begin
            r_req <= i_req.data;
        end
    end

    por_date_conv u_conv_s1 (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_day     (r_req.first_start_day),
        .i_month   (r_req.first_start_month),
        .i_year    (r_req.first_start_year),
        .o_day_num (w_s1),
        .o_ok      (w_ok_s1)
    );

    por_date_conv u_conv_e1 (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_day     (r_req.first_end_day),
        .i_month   (r_req.first_end_month),
        .i_year    (r_req.first_end_year),
        .o_day_num (w_e1),
        .o_ok      (w_ok_e1)
    );

    por_date_conv u_conv_s2 (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_day     (r_req.second_start_day),
        .i_month   (r_req.second_start_month),
        .i_year    (r_req.second_start_year),
        .o_day_num (w_s2),
        .o_ok      (w_ok_s2)
    );

    por_date_conv u_conv_e2 (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_day     (r_req.second_end_day),
        .i_month   (r_req.second_end_month),
        .i_year    (r_req.second_end_year),
        .o_day_num (w_e2),
        .o_ok      (w_ok_e2)
    );

    // Overlap is [later start, earlier end]; empty when that range inverts
    always_comb begin
        w_ok = w_ok_s1 && w_ok_e1 && w_ok_s2 && w_ok_e2;
        w_lo = (w_s1 > w_s2) ? w_s1 : w_s2;
        w_hi = (w_e1 < w_e2) ? w_e1 : w_e2;
        n_rsp.bad_date = !w_ok;
        if (w_ok && (w_hi >= w_lo)) begin
            n_rsp.overlap_days = w_hi - w_lo + por_pkg::DNUM_W'(1);
        end else begin
            n_rsp.overlap_days = '0;
        end
    end

    // Result register: hold the response until its transfer out
    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_v3;
    assign o_rsp.data  = r_rsp;

endmodule

>>> hw/rtl/por_date_conv.sv
module por_date_conv (
    input  logic                                 i_clk,
    input  por_pkg::t_stage_en                   i_en,
    input  logic [por_pkg::DAY_W-1:0]            i_day,
    input  logic [por_pkg::MONTH_W-1:0]          i_month,
    input  logic [por_pkg::YEAR_W-1:0]           i_year,
    output logic [por_pkg::DNUM_W-1:0]           o_day_num,
    output logic                                 o_ok
);

    localparam int unsigned PROD_W = por_pkg::YEAR_W + por_pkg::RECIP_W;
    localparam int unsigned HUND_W = por_pkg::Q100_W + 7;

    logic [PROD_W-1:0]               w_prod;
    logic [por_pkg::Q100_W-1:0]      w_q_y;
    logic [HUND_W-1:0]               w_hund;
    logic                            w_div100;
    logic                            w_div400;
    logic                            w_leap;
    logic                            w_early;
    logic [por_pkg::DAY_W-1:0]       w_lim;

    logic [por_pkg::YEAR_W-1:0]      n_yy,  r_yy;
    logic [por_pkg::Q100_W-1:0]      n_q,   r_q;
    logic [por_pkg::DOY_W-1:0]       n_doy, r_doy;
    logic                            n_ok1, r_ok1;
    logic [por_pkg::DNUM_W-1:0]      n_day_num, r_day_num;
    logic                            r_ok2;

    // Stage 1: leap rule, validity, March-based year and day of year
    assign w_prod   = PROD_W'(i_year) * PROD_W'(por_pkg::RECIP_100);
    assign w_q_y    = w_prod[PROD_W-1 -: por_pkg::Q100_W];
    assign w_hund   = HUND_W'(w_q_y) * HUND_W'(100);
    assign w_div100 = (w_hund == HUND_W'(i_year));
    assign w_div400 = w_div100 && (w_q_y[1:0] == 2'd0);
    assign w_leap   = ((i_year[1:0] == 2'd0) && !w_div100) || w_div400;
    assign w_early  = (i_month == por_pkg::MONTH_JAN) || (i_month == por_pkg::MONTH_FEB);
    assign w_lim    = por_pkg::month_len(i_month, w_leap);

    always_comb begin
        n_yy  = w_early ? (i_year - por_pkg::YEAR_W'(1)) : i_year;
        // year before a century year drops one from the hundreds count
        n_q   = (w_early && w_div100) ? (w_q_y - por_pkg::Q100_W'(1)) : w_q_y;
        n_doy = por_pkg::march_offset(i_month) + por_pkg::DOY_W'(i_day)
              - por_pkg::DOY_W'(1);
        n_ok1 = (i_month >= por_pkg::MONTH_JAN) && (i_month <= por_pkg::MONTH_DEC)
             && (i_year != '0) && (i_year <= por_pkg::YEAR_MAX)
             && (i_day != '0) && (i_day <= w_lim);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_yy  <= n_yy;
            r_q   <= n_q;
            r_doy <= n_doy;
            r_ok1 <= n_ok1;
        end
    end

    // Stage 2: serial day number
    always_comb begin
        n_day_num = por_pkg::DNUM_W'(r_yy) * por_pkg::DAYS_PER_YEAR
                  + por_pkg::DNUM_W'(r_yy >> 2)
                  - por_pkg::DNUM_W'(r_q)
                  + por_pkg::DNUM_W'(r_q >> 2)
                  + por_pkg::DNUM_W'(r_doy);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_day_num <= n_day_num;
            r_ok2     <= r_ok1;
        end
    end

    assign o_day_num = r_day_num;
    assign o_ok      = r_ok2;

endmodule

>>> verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import por_pkg::*;

    // Pipe depth given at the head of the block, plus a margin for the drain.
    localparam int unsigned PIPE_DEPTH   = 4;
    localparam int unsigned DRAIN_CYCLES = PIPE_DEPTH + 8;
    // Slowest correct run: ~700 transfers, each after the longest sender gap and
    // behind the longest response stall, stays far below this limit.
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } cal_date_t;

    logic i_clk;
    logic i_rst_n;

    por_req_if req_if ();
    por_rsp_if rsp_if ();

    period_overlap_day_count dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_rsp_data   expected_overlaps[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    // Random gaps on the request side and stalls on the response side.
    bit          pacing_on      = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Calendar arithmetic for the prediction
    // ------------------------------------------------------------------

    // Gregorian rule: every fourth year, except centuries not divisible by 400.
    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        if (m == MONTH_FEB)
            return is_leap(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // Serial day number of a date, with the year counted from March so that
    // the leap day falls last. Returns 0 for an impossible date.
    function automatic bit date_serial(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                                       input logic [YEAR_W-1:0] y,
                                       output int unsigned serial);
        int unsigned dd, mm, yy, shifted, doy;
        dd = d;
        mm = m;
        yy = y;
        serial = 0;
        if (mm < MONTH_JAN || mm > MONTH_DEC || yy < 1 || yy > YEAR_MAX || dd < 1)
            return 1'b0;
        if (dd > month_days(mm, yy))
            return 1'b0;
        shifted = (mm <= MONTH_FEB) ? yy - 1 : yy;
        doy     = (153 * ((mm + 9) % 12) + 2) / 5 + dd - 1;
        serial  = 365 * shifted + shifted / 4 - shifted / 100 + shifted / 400 + doy;
        return 1'b1;
    endfunction

    // Days shared by both periods, end days included; any bad date gives 0.
    function automatic t_rsp_data predict_overlap(input t_req_data r);
        int unsigned s1, e1, s2, e2, lo, hi;
        bit          ok_s1, ok_e1, ok_s2, ok_e2;
        t_rsp_data   rsp;
        ok_s1 = date_serial(r.first_start_day, r.first_start_month, r.first_start_year, s1);
        ok_e1 = date_serial(r.first_end_day, r.first_end_month, r.first_end_year, e1);
        ok_s2 = date_serial(r.second_start_day, r.second_start_month, r.second_start_year, s2);
        ok_e2 = date_serial(r.second_end_day, r.second_end_month, r.second_end_year, e2);
        rsp.overlap_days = '0;
        rsp.bad_date     = !(ok_s1 && ok_e1 && ok_s2 && ok_e2);
        if (!rsp.bad_date) begin
            lo = (s1 > s2) ? s1 : s2;
            hi = (e1 < e2) ? e1 : e2;
            if (hi >= lo)
                rsp.overlap_days = DNUM_W'(hi - lo + 1);
        end
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic cal_date_t mk_date(input int unsigned d, input int unsigned m,
                                          input int unsigned y);
        cal_date_t dt;
        dt.day   = DAY_W'(d);
        dt.month = MONTH_W'(m);
        dt.year  = YEAR_W'(y);
        return dt;
    endfunction

    function automatic cal_date_t random_date(input int unsigned y_lo, input int unsigned y_hi);
        cal_date_t dt;
        dt.year  = YEAR_W'($urandom_range(y_hi, y_lo));
        dt.month = MONTH_W'($urandom_range(MONTH_DEC, MONTH_JAN));
        dt.day   = DAY_W'($urandom_range(month_days(dt.month, dt.year), 1));
        return dt;
    endfunction

    // Mostly well-ordered periods; now and then leave one reversed (empty).
    function automatic void random_period(input int unsigned y_lo, input int unsigned y_hi,
                                          output cal_date_t p_start, output cal_date_t p_end);
        cal_date_t   a, b;
        int unsigned sa, sb;
        a = random_date(y_lo, y_hi);
        b = random_date(y_lo, y_hi);
        void'(date_serial(a.day, a.month, a.year, sa));
        void'(date_serial(b.day, b.month, b.year, sb));
        if (sa > sb && $urandom_range(9, 0) != 0) begin
            p_start = b;
            p_end   = a;
        end else begin
            p_start = a;
            p_end   = b;
        end
    endfunction

    // Present one request at the falling edge and hold it until the transfer.
    task automatic send_periods(input cal_date_t fs, input cal_date_t fe,
                                input cal_date_t ss, input cal_date_t se);
        t_req_data item;
        item.first_start_day    = fs.day;
        item.first_start_month  = fs.month;
        item.first_start_year   = fs.year;
        item.first_end_day      = fe.day;
        item.first_end_month    = fe.month;
        item.first_end_year     = fe.year;
        item.second_start_day   = ss.day;
        item.second_start_month = ss.month;
        item.second_start_year  = ss.year;
        item.second_end_day     = se.day;
        item.second_end_month   = se.month;
        item.second_end_year    = se.year;
        @(negedge i_clk);
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        do @(posedge i_clk); while (!req_if.ready);
        // Drop valid for a burst now and then; otherwise keep it high so the
        // next request follows back to back.
        if (pacing_on && $urandom_range(3, 0) == 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat ($urandom_range(7, 1) - 1) @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_extreme_ranges();
        // Whole calendar against itself: the largest count the block can give.
        send_periods(mk_date(1, 1, 1), mk_date(31, 12, 9999),
                     mk_date(1, 1, 1), mk_date(31, 12, 9999));
        // One shared day.
        send_periods(mk_date(15, 6, 2024), mk_date(15, 6, 2024),
                     mk_date(15, 6, 2024), mk_date(15, 6, 2024));
        // Last year of the range.
        send_periods(mk_date(1, 1, 9999), mk_date(31, 12, 9999),
                     mk_date(30, 11, 9999), mk_date(31, 12, 9999));
        // January and February of year one, before the first March.
        send_periods(mk_date(1, 1, 1), mk_date(28, 2, 1),
                     mk_date(15, 2, 1), mk_date(10, 3, 1));
        // Across a year end.
        send_periods(mk_date(15, 12, 1999), mk_date(15, 1, 2000),
                     mk_date(1, 1, 2000), mk_date(31, 12, 2000));
        // Second period wholly inside the first.
        send_periods(mk_date(1, 1, 1800), mk_date(31, 12, 2200),
                     mk_date(7, 8, 1969), mk_date(20, 7, 2069));
    endtask

    task automatic test_leap_rules();
        // Century divisible by 400: 29 February exists.
        send_periods(mk_date(28, 2, 2000), mk_date(1, 3, 2000),
                     mk_date(29, 2, 2000), mk_date(29, 2, 2000));
        // Century not divisible by 400: it does not.
        send_periods(mk_date(29, 2, 1900), mk_date(1, 3, 1900),
                     mk_date(1, 1, 1900), mk_date(31, 12, 1900));
        // Ordinary leap year: all of February.
        send_periods(mk_date(1, 2, 2004), mk_date(1, 3, 2004),
                     mk_date(1, 2, 2004), mk_date(29, 2, 2004));
        // Ordinary common year.
        send_periods(mk_date(1, 2, 2001), mk_date(29, 2, 2001),
                     mk_date(1, 2, 2001), mk_date(28, 2, 2001));
    endtask

    task automatic test_invalid_dates();
        cal_date_t ok_s, ok_e;
        ok_s = mk_date(1, 1, 2020);
        ok_e = mk_date(31, 12, 2020);
        send_periods(mk_date(0, 5, 2020), ok_e, ok_s, ok_e);        // day zero
        send_periods(ok_s, mk_date(31, 4, 2021), ok_s, ok_e);       // past month end
        send_periods(ok_s, ok_e, mk_date(10, 0, 2020), ok_e);       // month zero
        send_periods(ok_s, ok_e, ok_s, mk_date(10, 13, 2020));      // month 13
        send_periods(mk_date(31, 15, 16383), ok_e, ok_s, ok_e);     // all bits set
        send_periods(ok_s, mk_date(1, 1, 0), ok_s, ok_e);           // year zero
        send_periods(ok_s, ok_e, mk_date(1, 1, 10000), ok_e);       // year past range
        send_periods(ok_s, ok_e, ok_s, mk_date(31, 6, 2020));       // only the last date bad
    endtask

    task automatic test_empty_and_disjoint();
        // First period reversed, second covers everything.
        send_periods(mk_date(10, 3, 2000), mk_date(9, 3, 2000),
                     mk_date(1, 1, 1), mk_date(31, 12, 9999));
        // Both reversed.
        send_periods(mk_date(2, 1, 500), mk_date(1, 1, 500),
                     mk_date(31, 12, 9999), mk_date(1, 1, 1));
        // Disjoint by a year.
        send_periods(mk_date(1, 1, 2020), mk_date(31, 1, 2020),
                     mk_date(1, 1, 2021), mk_date(31, 1, 2021));
        // Touching at one day.
        send_periods(mk_date(1, 1, 2020), mk_date(31, 1, 2020),
                     mk_date(31, 1, 2020), mk_date(28, 2, 2020));
    endtask

    // Well-formed periods in a window around a random year: mostly narrow
    // windows so the periods overlap often, a few spanning the whole range.
    task automatic test_random_periods(input int unsigned n);
        cal_date_t   fs, fe, ss, se;
        int unsigned sel, base, span, y_lo, y_hi;
        repeat (n) begin
            sel  = $urandom_range(9, 0);
            base = $urandom_range(YEAR_MAX, 1);
            span = (sel < 6) ? $urandom_range(1, 0) : $urandom_range(20, 2);
            y_lo = (base > span) ? base - span : 1;
            y_hi = (base + span > YEAR_MAX) ? YEAR_MAX : base + span;
            if (sel == 9) begin
                y_lo = 1;
                y_hi = YEAR_MAX;
            end
            random_period(y_lo, y_hi, fs, fe);
            random_period(y_lo, y_hi, ss, se);
            send_periods(fs, fe, ss, se);
        end
    endtask

    // Half raw bit patterns, half sound requests with one field corrupted.
    task automatic test_malformed_dates(input int unsigned n);
        cal_date_t   dates[4];
        int unsigned base, k;
        repeat (n) begin
            base = $urandom_range(YEAR_MAX - 1, 1);
            random_period(base, base + 1, dates[0], dates[1]);
            random_period(base, base + 1, dates[2], dates[3]);
            if ($urandom_range(1, 0) == 0) begin
                for (int i = 0; i < 4; i++)
                    dates[i] = mk_date($urandom_range(31, 0), $urandom_range(15, 0),
                                       $urandom_range(16383, 0));
            end else begin
                k = $urandom_range(3, 0);
                case ($urandom_range(2, 0))
                    0:       dates[k].day   = DAY_W'($urandom_range(31, 0));
                    1:       dates[k].month = MONTH_W'($urandom_range(15, 0));
                    default: dates[k].year  = YEAR_W'($urandom_range(16383, 0));
                endcase
            end
            send_periods(dates[0], dates[1], dates[2], dates[3]);
        end
    endtask

    // ------------------------------------------------------------------
    // Response side: stall in random bursts while pacing is on
    // ------------------------------------------------------------------
    initial begin
        rsp_if.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (pacing_on && $urandom_range(5, 0) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(7, 1)) @(negedge i_clk);
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: predict on each request transfer, check each response
    // transfer against the oldest prediction. One process, so the order of
    // push and pop within an edge never matters.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp_data want;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                expected_overlaps.push_back(predict_overlap(req_if.data));
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_overlaps.size() == 0) begin
                    $error("response with nothing expected: overlap_days %0d, bad_date %0d",
                           rsp_if.data.overlap_days, rsp_if.data.bad_date);
                    mismatch_count++;
                end else begin
                    want = expected_overlaps.pop_front();
                    if (rsp_if.data.overlap_days !== want.overlap_days) begin
                        $error("overlap_days mismatch: expected %0d, actual %0d",
                               want.overlap_days, rsp_if.data.overlap_days);
                        mismatch_count++;
                    end
                    if (rsp_if.data.bad_date !== want.bad_date) begin
                        $error("bad_date mismatch: expected %0d, actual %0d",
                               want.bad_date, rsp_if.data.bad_date);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------
    initial begin
        // Drive every input to a known value before the first edge.
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extreme_ranges();
        test_leap_rules();
        test_invalid_dates();
        test_empty_and_disjoint();
        test_random_periods(480);
        test_malformed_dates(120);
        // Final stretch at full rate on both sides.
        pacing_on = 1'b0;
        test_random_periods(80);

        @(negedge i_clk);
        req_if.valid <= 1'b0;

        // Wait for every outstanding response, then keep watching for the drain margin
        // to catch anything unexpected coming out of the pipe.
        while (expected_overlaps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_overlaps.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
